// ----- sv/ssg_pkg.sv -----
// shared constants and codes for the sine sample generator
`timescale 1ns / 1ps

package ssg_pkg;

   // default configuration of the generator
   localparam int PHASE_BITS_DEF      = 32;
   localparam int SINE_INDEX_BITS_DEF = 12;
   localparam int SAMPLE_BITS_DEF     = 16;

   // sample counter width, fixed by the register map
   localparam int COUNT_BITS = 24;

   // pi/2 in unsigned Q2.62
   localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

   // register indexes on the csr port
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AMPLITUDE    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLE_COUNT = 2'd2;

   // result status codes
   localparam int STATUS_BITS = 2;
   localparam logic [STATUS_BITS-1:0] ST_SAMPLE = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_STOP   = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_DONE   = 2'd2;

endpackage

// ----- sv/ssg_sine_lut.sv -----
// quarter-wave sine table with quadrant folding and registered read
`timescale 1ns / 1ps

module ssg_sine_lut
   import ssg_pkg::*;
#(
   parameter int SINE_INDEX_BITS = SINE_INDEX_BITS_DEF,
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [SINE_INDEX_BITS-1:0]    rd_index,
   output logic signed [SAMPLE_BITS-1:0] rd_sine
);

   localparam int QUARTER = 1 << (SINE_INDEX_BITS - 2);
   localparam int ADDR_BITS = SINE_INDEX_BITS - 1;
   localparam logic [63:0] PEAK = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

   // angle step per table entry, quotient and remainder of pi/2 over the quarter
   localparam logic [63:0] STEP_Q = HALF_PI_Q62 / QUARTER;
   localparam logic [63:0] STEP_R = HALF_PI_Q62 % QUARTER;

   typedef logic signed [SAMPLE_BITS-1:0] qtab_type [0:QUARTER];

   // shift-subtract division, only used while the table is built
   function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // round(PEAK * sin(pi/2 * m / QUARTER)) by a Q62 taylor series
   function automatic qtab_type build_qtab();
      qtab_type     t;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [127:0] p;
      logic         done;
      for (int m = 0; m <= QUARTER; m++) begin
         x = STEP_Q * 64'(m) + ((STEP_R * 64'(m)) >> (SINE_INDEX_BITS - 2));
         p = {64'd0, x} * {64'd0, x};
         x2 = p[125:62];
         term = x;
         sum = x;
         done = 1'b0;
         for (int n = 1; n < 40; n++) begin
            if (!done) begin
               p = {64'd0, term} * {64'd0, x2};
               term = div_u64(p[125:62], 64'(2 * n) * 64'(2 * n + 1));
               if (term == 64'd0) begin
                  done = 1'b1;
               end else if (n[0]) begin
                  sum = sum - term;
               end else begin
                  sum = sum + term;
               end
            end
         end
         p = {64'd0, sum} * {64'd0, PEAK} + (128'd1 << 61);
         t[m] = p[62 +: SAMPLE_BITS];
      end
      return t;
   endfunction

   localparam qtab_type QTAB = build_qtab();

   logic [ADDR_BITS-1:0]         addr;
   logic                         negate;
   logic [SINE_INDEX_BITS-3:0]   offset;
   logic signed [SAMPLE_BITS-1:0] entry;
   logic signed [SAMPLE_BITS-1:0] rd_sine_ff;

   // odd quadrants run the table backwards, upper half is negated
   always_comb begin
      offset = rd_index[SINE_INDEX_BITS-3:0];
      negate = rd_index[SINE_INDEX_BITS-1];
      if (rd_index[SINE_INDEX_BITS-2]) begin
         addr = ADDR_BITS'(QUARTER) - {1'b0, offset};
      end else begin
         addr = {1'b0, offset};
      end
      entry = QTAB[addr];
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_sine_ff <= negate ? -entry : entry;
      end
   end

   assign rd_sine = rd_sine_ff;

endmodule

// ----- sv/sine_sample_generator_core.sv -----
// top level of the sine sample generator (phase accumulator nco)
`timescale 1ns / 1ps

// path: an accepted item passes the table read register, then the multiply
//   goes straight into the output register, where rsp_valid rises
// throughput: one item per cycle while rsp_ready does not stall the output;
//   the table read register and the output register each hold one item
// reset: synchronous, clears valid flags, configuration registers, phase,
//   sample index and stop flag; no clearing pass, an item can be taken as soon as reset is released

module sine_sample_generator_core
   import ssg_pkg::*;
#(
   parameter int PHASE_BITS      = PHASE_BITS_DEF,
   parameter int SINE_INDEX_BITS = SINE_INDEX_BITS_DEF,
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // tick items
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_restart,
   // sample items
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   output logic [STATUS_BITS-1:0]        rsp_status,
   // register writes
   input  logic                          csr_we,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [((PHASE_BITS > COUNT_BITS) ? PHASE_BITS : COUNT_BITS)-1:0] csr_wdata
);

   // configuration registers
   logic signed [SAMPLE_BITS-1:0] amplitude_ff;
   logic [PHASE_BITS-1:0]         phase_step_ff;
   logic [COUNT_BITS-1:0]         sample_count_ff;

   // generator state
   logic [PHASE_BITS-1:0]         phase_ff, phase_in;
   logic [COUNT_BITS-1:0]         index_ff, index_in;
   logic                          stop_sent_ff, stop_sent_in;

   // tick view after an optional restart
   logic [PHASE_BITS-1:0]         cur_phase;
   logic [COUNT_BITS-1:0]         cur_index;
   logic                          cur_stop;
   logic                          running;
   logic [STATUS_BITS-1:0]        status_in;

   // pipeline control
   logic                          accept;
   logic                          out_free;
   logic                          s1_valid_ff;
   logic [STATUS_BITS-1:0]        s1_status_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sine;

   // multiply stage
   logic signed [2*SAMPLE_BITS-1:0] product;
   logic signed [2*SAMPLE_BITS-1:0] scaled;
   logic signed [SAMPLE_BITS-1:0]   sample_in;

   // output register
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic [STATUS_BITS-1:0]        rsp_status_ff;

   // ------------------------------------------------------------------
   // handshake: a stage moves when the one after it is empty or moving
   // ------------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   // ------------------------------------------------------------------
   // register writes, unknown indexes are dropped
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         amplitude_ff    <= '0;
         phase_step_ff   <= '0;
         sample_count_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_AMPLITUDE:    amplitude_ff    <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_PHASE_STEP:   phase_step_ff   <= csr_wdata[PHASE_BITS-1:0];
            CSR_SAMPLE_COUNT: sample_count_ff <= csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // tick: restart first, then sample, stop marker or finished
   // ------------------------------------------------------------------
   always_comb begin
      cur_phase = req_restart ? '0 : phase_ff;
      cur_index = req_restart ? '0 : index_ff;
      cur_stop  = req_restart ? 1'b0 : stop_sent_ff;
      running   = cur_index < sample_count_ff;

      if (running) begin
         status_in    = ST_SAMPLE;
         phase_in     = cur_phase + phase_step_ff;
         index_in     = cur_index + COUNT_BITS'(1);
         stop_sent_in = cur_stop;
      end else begin
         status_in    = cur_stop ? ST_DONE : ST_STOP;
         phase_in     = cur_phase;
         index_in     = cur_index;
         stop_sent_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         index_ff     <= '0;
         stop_sent_ff <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         index_ff     <= index_in;
         stop_sent_ff <= stop_sent_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 1: table read at the top phase bits
   // ------------------------------------------------------------------
   ssg_sine_lut #(
      .SINE_INDEX_BITS (SINE_INDEX_BITS),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_sine_lut (
      .clock    (clock),
      .rd_en    (accept),
      .rd_index (cur_phase[PHASE_BITS-1 -: SINE_INDEX_BITS]),
      .rd_sine  (s1_sine)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (accept) begin
         s1_status_ff <= status_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: scale by amplitude, floor shift back to sample units
   // ------------------------------------------------------------------
   always_comb begin
      product = amplitude_ff * s1_sine;
      scaled  = product >>> (SAMPLE_BITS - 1);
      if (s1_status_ff == ST_SAMPLE) begin
         sample_in = scaled[SAMPLE_BITS-1:0];
      end else begin
         sample_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (out_free && s1_valid_ff) begin
         rsp_sample_ff <= sample_in;
         rsp_status_ff <= s1_status_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_status = rsp_status_ff;

`ifndef SYNTH
   // stop marker and finished items never carry a sample value
   a_quiet_when_not_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_SAMPLE) |-> rsp_sample_ff == '0)
      else $error("non-sample item with nonzero sample");

   // any item that is not a sample leaves the stop flag set
   a_stop_flag_set: assert property (@(posedge clock) disable iff (reset)
      accept && !running |=> stop_sent_ff)
      else $error("stop flag not set after end of run");

   // every sample advances the index by exactly one
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      accept && running |=> index_ff == $past(cur_index) + COUNT_BITS'(1))
      else $error("sample index did not advance");

   // an item in stage 1 stays there while the output register is blocked
   a_stage1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_status_ff))
      else $error("stage 1 item lost under stall");
`endif

endmodule
